@@ src/cau_pkg.sv @@
package cau_pkg;

   // word format
   localparam int WordBits = 32;
   localparam int FracBits = 16;

   // internal widths
   localparam int ProdBits = 2 * WordBits;
   localparam int MagBits  = WordBits + 1;
   localparam int SqBits   = 2 * WordBits + 1;
   localparam int RemBits  = 3 * WordBits + FracBits;

   // front queue
   localparam int QueueDepth = 2;
   localparam int PtrBits    = 1;
   localparam int CountBits  = 2;

   // operation codes
   localparam logic [2:0] OpAdd  = 3'd0;
   localparam logic [2:0] OpSub  = 3'd1;
   localparam logic [2:0] OpMul  = 3'd2;
   localparam logic [2:0] OpDiv  = 3'd3;
   localparam logic [2:0] OpConj = 3'd4;
   localparam logic [2:0] OpMod  = 3'd5;
   localparam logic [2:0] OpCmp  = 3'd6;

   // status codes
   localparam logic [1:0] StatOk      = 2'd0;
   localparam logic [1:0] StatDivZero = 2'd1;
   localparam logic [1:0] StatSat     = 2'd2;

   typedef struct packed {
      logic [2:0]                 action;
      logic signed [WordBits-1:0] a_re;
      logic signed [WordBits-1:0] a_im;
      logic signed [WordBits-1:0] b_re;
      logic signed [WordBits-1:0] b_im;
   } cau_req_type;

   typedef struct packed {
      logic signed [WordBits-1:0] res_re;
      logic signed [WordBits-1:0] res_im;
      logic                       equal_flag;
      logic [1:0]                 status;
   } cau_rsp_type;

   // classified transaction between front and back
   typedef struct packed {
      cau_req_type req;
      logic        b_zero;
      logic        equal;
   } cau_item_type;

endpackage

@@ src/cau_front.sv @@
module cau_front (
   input  logic                 req_valid,
   output logic                 req_stall,
   input  cau_pkg::cau_req_type req,
   input  logic                 queue_full,
   output logic                 push,
   output cau_pkg::cau_item_type item
);
   import cau_pkg::*;

   // accept while the queue has room
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // classify: zero divisor and equality
   always_comb begin
      item.req    = req;
      item.b_zero = (req.b_re == '0) && (req.b_im == '0);
      item.equal  = (req.action == OpCmp) && (req.a_re == req.b_re) &&
                    (req.a_im == req.b_im);
   end

endmodule

@@ src/cau_queue.sv @@
module cau_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cau_pkg::cau_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output cau_pkg::cau_item_type head_item
);
   import cau_pkg::*;

   cau_item_type         entry_ff [QueueDepth];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0] count_ff, count_in;

   assign full       = (count_ff == CountBits'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PtrBits'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PtrBits'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CountBits'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CountBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ src/cau_back.sv @@
module cau_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  cau_pkg::cau_item_type item,
   output logic                  item_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cau_pkg::cau_rsp_type  rsp
);
   import cau_pkg::*;

   typedef struct packed {
      logic [2:0]                 action;
      logic                       b_zero;
      logic                       equal;
      logic signed [WordBits:0]   lin_re;
      logic signed [WordBits:0]   lin_im;
      logic signed [ProdBits-1:0] p_rr;
      logic signed [ProdBits-1:0] p_ii;
      logic signed [ProdBits-1:0] p_ri;
      logic signed [ProdBits-1:0] p_ir;
      logic signed [ProdBits-1:0] q_x;
      logic signed [ProdBits-1:0] q_y;
   } prod_type;

   typedef struct packed {
      logic [2:0]          action;
      logic                b_zero;
      logic                equal;
      logic                re_neg;
      logic [MagBits-1:0]  re_mag;
      logic                im_neg;
      logic [MagBits-1:0]  im_mag;
      logic [ProdBits-1:0] den;
      logic [RemBits-1:0]  rre;
      logic [RemBits-1:0]  rim;
      logic [WordBits-1:0] qre;
      logic [WordBits-1:0] qim;
      logic                big_re;
      logic                big_im;
      logic [SqBits-1:0]   srem;
      logic [WordBits-1:0] root;
   } iter_type;

   function automatic logic [ProdBits-1:0] mag_p(input logic signed [ProdBits:0] x);
      logic signed [ProdBits:0] n;
      n = x[ProdBits] ? -x : x;
      return n[ProdBits-1:0];
   endfunction

   function automatic logic [MagBits-1:0] clamp_m(input logic [ProdBits-1:0] x);
      logic [MagBits-1:0] r;
      if (|x[ProdBits-1:MagBits]) begin
         r = {1'b1, {WordBits{1'b0}}};
      end else begin
         r = x[MagBits-1:0];
      end
      return r;
   endfunction

   // returns {saturated, value}
   function automatic logic [WordBits:0] sat_part(input logic neg,
                                                   input logic [MagBits-1:0] mag);
      logic [MagBits-1:0]  lim;
      logic [WordBits-1:0] v;
      logic                s;
      lim = neg ? {2'b01, {(WordBits-1){1'b0}}} : {2'b00, {(WordBits-1){1'b1}}};
      s   = (mag > lim);
      if (s) begin
         v = neg ? {1'b1, {(WordBits-1){1'b0}}} : {1'b0, {(WordBits-1){1'b1}}};
      end else begin
         v = neg ? -mag[WordBits-1:0] : mag[WordBits-1:0];
      end
      return {s, v};
   endfunction

   logic     adv;
   logic     rsp_valid_ff;
   cau_rsp_type rsp_ff, rsp_in;
   logic     v1_ff, v2_ff;
   logic [WordBits-1:0] lv_ff;
   prod_type s1_ff, s1_in;
   iter_type s2_ff, s2_in;
   iter_type lp_ff [WordBits];

   // whole pipe moves unless the output is held
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign item_pop  = item_valid && adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // stage 1: linear ops and products
   always_comb begin
      logic signed [WordBits:0]   ar1, ai1, br1, bi1;
      logic signed [WordBits-1:0] sx, sy;
      ar1 = (WordBits+1)'(item.req.a_re);
      ai1 = (WordBits+1)'(item.req.a_im);
      br1 = (WordBits+1)'(item.req.b_re);
      bi1 = (WordBits+1)'(item.req.b_im);
      s1_in.action = item.req.action;
      s1_in.b_zero = item.b_zero;
      s1_in.equal  = item.equal;
      case (item.req.action)
         OpAdd: begin
            s1_in.lin_re = ar1 + br1;
            s1_in.lin_im = ai1 + bi1;
         end
         OpSub: begin
            s1_in.lin_re = ar1 - br1;
            s1_in.lin_im = ai1 - bi1;
         end
         OpConj: begin
            s1_in.lin_re = ar1;
            s1_in.lin_im = -ai1;
         end
         default: begin
            s1_in.lin_re = '0;
            s1_in.lin_im = '0;
         end
      endcase
      sx = (item.req.action == OpMod) ? item.req.a_re : item.req.b_re;
      sy = (item.req.action == OpMod) ? item.req.a_im : item.req.b_im;
      s1_in.p_rr = item.req.a_re * item.req.b_re;
      s1_in.p_ii = item.req.a_im * item.req.b_im;
      s1_in.p_ri = item.req.a_re * item.req.b_im;
      s1_in.p_ir = item.req.a_im * item.req.b_re;
      s1_in.q_x  = sx * sx;
      s1_in.q_y  = sy * sy;
   end

   // stage 2: cross sums, magnitudes, divisor
   always_comb begin
      logic signed [ProdBits:0] mre, mim, dre, dim;
      logic signed [WordBits:0] lre, lim;
      mre = (ProdBits+1)'(s1_ff.p_rr) - (ProdBits+1)'(s1_ff.p_ii);
      mim = (ProdBits+1)'(s1_ff.p_ri) + (ProdBits+1)'(s1_ff.p_ir);
      dre = (ProdBits+1)'(s1_ff.p_rr) + (ProdBits+1)'(s1_ff.p_ii);
      dim = (ProdBits+1)'(s1_ff.p_ir) - (ProdBits+1)'(s1_ff.p_ri);
      lre = s1_ff.lin_re[WordBits] ? -s1_ff.lin_re : s1_ff.lin_re;
      lim = s1_ff.lin_im[WordBits] ? -s1_ff.lin_im : s1_ff.lin_im;
      s2_in.action = s1_ff.action;
      s2_in.b_zero = s1_ff.b_zero;
      s2_in.equal  = s1_ff.equal;
      case (s1_ff.action)
         OpAdd, OpSub, OpConj: begin
            s2_in.re_neg = s1_ff.lin_re[WordBits];
            s2_in.re_mag = lre;
            s2_in.im_neg = s1_ff.lin_im[WordBits];
            s2_in.im_mag = lim;
         end
         OpMul: begin
            s2_in.re_neg = mre[ProdBits];
            s2_in.re_mag = clamp_m(mag_p(mre) >> FracBits);
            s2_in.im_neg = mim[ProdBits];
            s2_in.im_mag = clamp_m(mag_p(mim) >> FracBits);
         end
         OpDiv: begin
            s2_in.re_neg = dre[ProdBits];
            s2_in.re_mag = '0;
            s2_in.im_neg = dim[ProdBits];
            s2_in.im_mag = '0;
         end
         default: begin
            s2_in.re_neg = 1'b0;
            s2_in.re_mag = '0;
            s2_in.im_neg = 1'b0;
            s2_in.im_mag = '0;
         end
      endcase
      s2_in.den    = ProdBits'(s1_ff.q_x) + ProdBits'(s1_ff.q_y);
      s2_in.rre    = RemBits'(mag_p(dre)) << FracBits;
      s2_in.rim    = RemBits'(mag_p(dim)) << FracBits;
      s2_in.qre    = '0;
      s2_in.qim    = '0;
      s2_in.big_re = 1'b0;
      s2_in.big_im = 1'b0;
      s2_in.srem   = SqBits'(s2_in.den);
      s2_in.root   = '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
   end

   // quotient and root, one bit per stage
   for (genvar i = 0; i < WordBits; i++) begin : g_iter
      localparam int K = WordBits - 1 - i;
      iter_type          cur, nxt;
      logic [RemBits-1:0] dsh;
      logic [SqBits-1:0]  t;

      if (i == 0) begin : g_first
         assign cur = s2_ff;
      end else begin : g_next
         assign cur = lp_ff[i-1];
      end

      always_comb begin
         nxt = cur;
         dsh = RemBits'(cur.den) << K;
         t   = (SqBits'(cur.root) << (K + 1)) + (SqBits'(1) << (2 * K));
         if (i == 0) begin
            nxt.big_re = cur.rre >= (RemBits'(cur.den) << WordBits);
            nxt.big_im = cur.rim >= (RemBits'(cur.den) << WordBits);
         end
         if (cur.rre >= dsh) begin
            nxt.rre    = cur.rre - dsh;
            nxt.qre[K] = 1'b1;
         end
         if (cur.rim >= dsh) begin
            nxt.rim    = cur.rim - dsh;
            nxt.qim[K] = 1'b1;
         end
         if (cur.srem >= t) begin
            nxt.srem    = cur.srem - t;
            nxt.root[K] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            lp_ff[i] <= nxt;
         end
      end
   end

   // final select and saturation
   always_comb begin
      iter_type           fin;
      logic               rn, in_neg;
      logic [MagBits-1:0] rm, im;
      logic [WordBits:0]  sre, sim;
      fin = lp_ff[WordBits-1];
      rn = fin.re_neg;
      in_neg = fin.im_neg;
      rm = fin.re_mag;
      im = fin.im_mag;
      case (fin.action)
         OpDiv: begin
            rm = fin.big_re ? {1'b1, {WordBits{1'b0}}} : {1'b0, fin.qre};
            im = fin.big_im ? {1'b1, {WordBits{1'b0}}} : {1'b0, fin.qim};
         end
         OpMod: begin
            rn = 1'b0;
            rm = {1'b0, fin.root};
            in_neg = 1'b0;
            im = '0;
         end
         default: begin
         end
      endcase
      sre = sat_part(rn, rm);
      sim = sat_part(in_neg, im);
      if ((fin.action == OpDiv) && fin.b_zero) begin
         rsp_in.res_re     = '0;
         rsp_in.res_im     = '0;
         rsp_in.equal_flag = 1'b0;
         rsp_in.status     = StatDivZero;
      end else begin
         rsp_in.res_re     = sre[WordBits-1:0];
         rsp_in.res_im     = sim[WordBits-1:0];
         rsp_in.equal_flag = fin.equal;
         rsp_in.status     = (sre[WordBits] || sim[WordBits]) ? StatSat : StatOk;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         lv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= item_valid;
         v2_ff        <= v1_ff;
         lv_ff        <= {lv_ff[WordBits-2:0], v2_ff};
         rsp_valid_ff <= lv_ff[WordBits-1];
      end
   end

endmodule

@@ src/complex_arith_unit.sv @@
// complex arithmetic unit: add, subtract, multiply, divide, conjugate,
// modulus and compare on complex operands in signed Q16.16.
// request channel: req_valid with req (action and operands A, B); a
// transaction is taken when req_valid is high and req_stall is low.
// response channel: rsp_valid with rsp (result parts, equal flag, status);
// a transaction completes when rsp_valid is high and rsp_stall is low.
// a two-entry queue sits between the classifying front and the pipelined
// back, so the request side keeps accepting while a response waits.
// path from request to response: queue storage, product stage, sum stage,
// 32 quotient/root bit stages and output register; the divider and square
// root resolve one bit per stage. throughput: one transaction per cycle,
// every operation, while rsp_stall does not hold a valid response.
// stall: when rsp_stall holds a valid response the whole back pipeline
// freezes; the queue fills and then req_stall rises.
// reset: clears the queue and all stage valid bits; no response pending.
module complex_arith_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  cau_pkg::cau_req_type req,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cau_pkg::cau_rsp_type rsp
);
   import cau_pkg::*;

   logic         push, queue_full, pop, head_valid;
   cau_item_type push_item, head_item;

   // classify incoming transactions
   cau_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req        (req),
      .queue_full (queue_full),
      .push       (push),
      .item       (push_item)
   );

   // decoupling queue
   cau_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // execution pipeline
   cau_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (head_valid),
      .item       (head_item),
      .item_pop   (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

endmodule
